// File: hw/rtl/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types and constants of the reply frame deframer.
// ----------------------------------------------------------------------------
package rfd_pkg;

  localparam int MAX_FRAME = 8192;
  localparam int CNT_W     = $clog2(MAX_FRAME + 1);
  localparam int IDX_W     = $clog2(MAX_FRAME);
  localparam int LIMIT_W   = 16;
  localparam int POLL_W    = 16;

  localparam logic [7:0] OPEN_MARK  = 8'h3C;
  localparam logic [7:0] CLOSE_MARK = 8'h3E;
  localparam logic [7:0] BIN_MARK   = 8'hC3;

  localparam int LEN_EXTRA      = 11;
  localparam int BASIC_LEN      = 2;
  localparam int HEADER_CHECK   = 2;
  localparam int LEN_LOW_POS    = 7;
  localparam int LEN_HIGH_POS   = 8;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd100;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_BYTE  = 2'd1,
    MODE_POLL  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BINARY = 2'd0,
    KIND_BASIC  = 2'd1,
    KIND_ASCII  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_COLLECT  = 3'd1,
    ST_DONE     = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] request_head;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    status_t          status;
    logic             kept_valid;
    logic [7:0]       kept_byte;
    logic [IDX_W-1:0] kept_index;
    logic             discard;
    logic [CNT_W-1:0] frame_length;
  } result_t;

endpackage

// File: hw/rtl/rfd_in_if.sv
// ----------------------------------------------------------------------------
// rfd_in_if
// Input item channel: start, received byte or poll tick.
// ----------------------------------------------------------------------------
interface rfd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] request_head;
  logic [7:0]  rx_byte;

  modport source (output valid, mode, request_head, rx_byte, input ready);
  modport sink (input valid, mode, request_head, rx_byte, output ready);
endinterface

// File: hw/rtl/rfd_out_if.sv
// ----------------------------------------------------------------------------
// rfd_out_if
// Result channel: status and the kept byte of one item.
// ----------------------------------------------------------------------------
interface rfd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        kept_valid;
  logic [7:0]  kept_byte;
  logic [12:0] kept_index;
  logic        discard;
  logic [13:0] frame_length;

  modport source (output valid, status, kept_valid, kept_byte, kept_index, discard,
                  frame_length, input ready);
  modport sink (input valid, status, kept_valid, kept_byte, kept_index, discard,
                frame_length, output ready);
endinterface

// File: hw/rtl/rfd_cfg_if.sv
// ----------------------------------------------------------------------------
// rfd_cfg_if
// Configuration write channel for the poll timeout limit.
// ----------------------------------------------------------------------------
interface rfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] poll_timeout_limit;

  modport source (output valid, poll_timeout_limit, input ready);
  modport sink (input valid, poll_timeout_limit, output ready);
endinterface

// File: hw/rtl/rfd_in_stage.sv
// ----------------------------------------------------------------------------
// rfd_in_stage
// Input register: holds one accepted item until the core takes it.
// ----------------------------------------------------------------------------
module rfd_in_stage (
  input  logic          clk,
  input  logic          rst,
  rfd_in_if.sink        items,
  input  logic          take,
  output logic          s1_valid,
  output rfd_pkg::item_t s1_item
);
  import rfd_pkg::*;

  logic accept;

  assign items.ready = !s1_valid || take;
  assign accept      = items.valid && items.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.mode         <= items.mode;
      s1_item.request_head <= items.request_head;
      s1_item.rx_byte      <= items.rx_byte;
    end
  end

endmodule

// File: hw/rtl/rfd_core.sv
// ----------------------------------------------------------------------------
// rfd_core
// Exchange state, per-item decode and the result register.
// ----------------------------------------------------------------------------
module rfd_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           s1_valid,
  input  rfd_pkg::item_t s1_item,
  output logic           take,
  rfd_cfg_if.sink        cfg,
  rfd_out_if.source      results
);
  import rfd_pkg::*;

  logic [LIMIT_W-1:0] limit;

  logic               active, active_next;
  kind_t              kind, kind_next;
  logic [CNT_W-1:0]   byte_count, byte_count_next;
  logic [7:0]         first_byte, first_byte_next;
  logic [7:0]         length_low, length_low_next;
  logic [3:0]         length_high, length_high_next;
  logic [POLL_W-1:0]  poll_count, poll_count_next;

  logic               res_valid;
  result_t            res, res_next;

  logic [CNT_W-1:0]   cnt_inc;
  logic [CNT_W-1:0]   len_sum;
  logic [7:0]         b;
  logic [7:0]         h0, h1;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg.valid) begin
      limit <= cfg.poll_timeout_limit;
    end
  end

  assign take = !res_valid || results.ready;

  always_comb begin
    b       = s1_item.rx_byte;
    h0      = s1_item.request_head[15:8];
    h1      = s1_item.request_head[7:0];
    cnt_inc = byte_count + CNT_W'(1);

    active_next      = active;
    kind_next        = kind;
    byte_count_next  = byte_count;
    first_byte_next  = first_byte;
    length_low_next  = length_low;
    length_high_next = length_high;
    poll_count_next  = poll_count;

    res_next              = '0;
    res_next.status       = ST_IDLE;

    if (byte_count == CNT_W'(0)) begin
      first_byte_next = b;
    end
    if (byte_count == CNT_W'(LEN_LOW_POS)) begin
      length_low_next = b;
    end
    if (byte_count == CNT_W'(LEN_HIGH_POS)) begin
      length_high_next = b[3:0];
    end
    len_sum = CNT_W'({length_high_next, length_low_next}) + CNT_W'(LEN_EXTRA);

    if (s1_item.mode == MODE_START) begin
      if (h0 == OPEN_MARK && h1 == BIN_MARK) begin
        kind_next = KIND_BINARY;
      end else if (h0 == OPEN_MARK) begin
        kind_next = KIND_ASCII;
      end else begin
        kind_next = KIND_BASIC;
      end
      active_next      = 1'b1;
      byte_count_next  = '0;
      first_byte_next  = '0;
      length_low_next  = '0;
      length_high_next = '0;
      poll_count_next  = '0;
      res_next.status  = ST_COLLECT;
    end else if (!active || !(s1_item.mode == MODE_BYTE || s1_item.mode == MODE_POLL)) begin
      first_byte_next  = first_byte;
      length_low_next  = length_low;
      length_high_next = length_high;
      res_next.status  = ST_IDLE;
    end else if (s1_item.mode == MODE_POLL) begin
      first_byte_next  = first_byte;
      length_low_next  = length_low;
      length_high_next = length_high;
      if (poll_count >= limit) begin
        active_next     = 1'b0;
        res_next.status = ST_TIMEOUT;
      end else begin
        poll_count_next = poll_count + POLL_W'(1);
        res_next.status = ST_COLLECT;
      end
    end else if (kind == KIND_BASIC) begin
      first_byte_next  = first_byte;
      length_low_next  = length_low;
      length_high_next = length_high;
      byte_count_next  = cnt_inc;
      if (cnt_inc >= CNT_W'(BASIC_LEN)) begin
        active_next           = 1'b0;
        res_next.status       = ST_DONE;
        res_next.frame_length = CNT_W'(BASIC_LEN);
      end else begin
        res_next.status = ST_COLLECT;
      end
    end else if (kind == KIND_ASCII && byte_count == CNT_W'(0) && b != OPEN_MARK) begin
      first_byte_next  = first_byte;
      length_low_next  = length_low;
      length_high_next = length_high;
      res_next.status  = ST_COLLECT;
    end else if (byte_count >= CNT_W'(MAX_FRAME)) begin
      first_byte_next  = first_byte;
      length_low_next  = length_low;
      length_high_next = length_high;
      active_next      = 1'b0;
      res_next.status  = ST_OVERFLOW;
    end else begin
      byte_count_next     = cnt_inc;
      res_next.kept_valid = 1'b1;
      res_next.kept_byte  = b;
      res_next.kept_index = byte_count[IDX_W-1:0];
      res_next.status     = ST_COLLECT;
      if (kind == KIND_ASCII) begin
        first_byte_next  = first_byte;
        length_low_next  = length_low;
        length_high_next = length_high;
        if (byte_count != CNT_W'(0) && b == CLOSE_MARK) begin
          active_next           = 1'b0;
          res_next.status       = ST_DONE;
          res_next.frame_length = cnt_inc;
        end
      end else if (cnt_inc == CNT_W'(HEADER_CHECK) &&
                   !(first_byte == OPEN_MARK && b == BIN_MARK)) begin
        byte_count_next  = '0;
        res_next.discard = 1'b1;
      end else if (cnt_inc >= CNT_W'(LEN_EXTRA) && b == CLOSE_MARK && len_sum == cnt_inc) begin
        active_next           = 1'b0;
        res_next.status       = ST_DONE;
        res_next.frame_length = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      kind        <= KIND_BINARY;
      byte_count  <= '0;
      first_byte  <= '0;
      length_low  <= '0;
      length_high <= '0;
      poll_count  <= '0;
      res_valid   <= 1'b0;
    end else if (take) begin
      res_valid <= s1_valid;
      if (s1_valid) begin
        active      <= active_next;
        kind        <= kind_next;
        byte_count  <= byte_count_next;
        first_byte  <= first_byte_next;
        length_low  <= length_low_next;
        length_high <= length_high_next;
        poll_count  <= poll_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && s1_valid) begin
      res <= res_next;
    end
  end

  assign results.valid        = res_valid;
  assign results.status       = res.status;
  assign results.kept_valid   = res.kept_valid;
  assign results.kept_byte    = res.kept_byte;
  assign results.kept_index   = res.kept_index;
  assign results.discard      = res.discard;
  assign results.frame_length = res.frame_length;

  a_kept_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kept_valid |-> res.status == ST_COLLECT || res.status == ST_DONE)
    else $error("kept byte with wrong status");

  a_discard_pos: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.discard |-> res.kept_valid && res.kept_index == IDX_W'(1))
    else $error("discard away from header check");

  a_len_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.frame_length != '0 |-> res.status == ST_DONE)
    else $error("frame length without completion");

  a_done_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_DONE && res.kept_valid |->
      res.frame_length == CNT_W'(res.kept_index) + CNT_W'(1))
    else $error("frame length does not match last index");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_W'(MAX_FRAME))
    else $error("byte count beyond frame limit");

endmodule

// File: hw/rtl/reply_frame_deframer.sv
// ----------------------------------------------------------------------------
// reply_frame_deframer
// Finds one reply frame (binary, ASCII or basic ASCII) in a received stream.
// ----------------------------------------------------------------------------
// items carries one of three kinds of item: a start that picks the frame
// kind from the first two request bytes, a received byte, or a poll tick.
// results returns exactly one result per item: status, the kept byte with
// its index, a discard flag when the binary header fails, and the frame
// length on completion. cfg writes the poll timeout limit; write it only
// while no item is in flight.
// Each item is held in the input register, where the per-item decode feeds
// the result register, from which its result is presented. One item per
// cycle is sustained while results does not stall; the single exchange
// state update in the core sets that figure.
// When results stalls, the result register holds and the input register
// fills; items.ready drops only when both hold an item.
// Reset (rst, synchronous) ends any exchange, empties both registers and
// sets the poll timeout limit to 100.
// ----------------------------------------------------------------------------
module reply_frame_deframer (
  input  logic      clk,
  input  logic      rst,
  rfd_in_if.sink    items,
  rfd_cfg_if.sink   cfg,
  rfd_out_if.source results
);
  import rfd_pkg::*;

  logic  take;
  logic  s1_valid;
  item_t s1_item;

  rfd_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .items    (items),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  rfd_core u_core (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .take     (take),
    .cfg      (cfg),
    .results  (results)
  );

endmodule

// File: bench/reply_frame_deframer_test.sv
// ----------------------------------------------------------------------------
// reply_frame_deframer_test
// Self-checking bench for the reply frame deframer. Directed tests walk each
// frame kind, header failure, timeout and a binary frame whose length uses
// the high nibble; random exchanges follow, with several timeout limits.
// Every result is checked field by field against a local prediction of the
// deframer, under random gaps on the input side and stalls on the output.
// ----------------------------------------------------------------------------
module reply_frame_deframer_test;
  import rfd_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 800000;

  logic clk = 1'b0;
  logic rst;

  rfd_in_if  items ();
  rfd_cfg_if cfg ();
  rfd_out_if results ();

  reply_frame_deframer u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .cfg     (cfg),
    .results (results)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted deframer state
  logic        fr_active;
  kind_t       fr_kind;
  int unsigned fr_count;
  logic [7:0]  fr_first;
  logic [7:0]  fr_len_lo;
  logic [3:0]  fr_len_hi;
  int unsigned fr_polls;
  logic [15:0] poll_limit;

  result_t reply_queue[$];
  int      error_count = 0;
  int      items_sent = 0;
  int      cycle_count = 0;
  bit      idling = 1'b1;

  function automatic result_t step_deframer(input item_t it);
    result_t     r;
    logic [7:0]  h0;
    logic [7:0]  h1;
    logic [7:0]  b;
    int unsigned idx;
    r = '0;
    r.status = ST_IDLE;
    h0 = it.request_head[15:8];
    h1 = it.request_head[7:0];
    b = it.rx_byte;
    if (it.mode == MODE_START) begin
      if (h0 == OPEN_MARK && h1 == BIN_MARK) fr_kind = KIND_BINARY;
      else if (h0 == OPEN_MARK) fr_kind = KIND_ASCII;
      else fr_kind = KIND_BASIC;
      fr_active = 1'b1;
      fr_count = 0;
      fr_first = '0;
      fr_len_lo = '0;
      fr_len_hi = '0;
      fr_polls = 0;
      r.status = ST_COLLECT;
      return r;
    end
    if (!fr_active || it.mode == MODE_UNUSED) return r;
    if (it.mode == MODE_POLL) begin
      if (fr_polls >= poll_limit) begin
        fr_active = 1'b0;
        r.status = ST_TIMEOUT;
      end else begin
        fr_polls++;
        r.status = ST_COLLECT;
      end
      return r;
    end
    if (fr_kind == KIND_BASIC) begin
      fr_count++;
      if (fr_count >= BASIC_LEN) begin
        fr_active = 1'b0;
        r.status = ST_DONE;
        r.frame_length = CNT_W'(BASIC_LEN);
      end else begin
        r.status = ST_COLLECT;
      end
      return r;
    end
    r.status = ST_COLLECT;
    if (fr_kind == KIND_ASCII && fr_count == 0 && b != OPEN_MARK) return r;
    if (fr_count >= MAX_FRAME) begin
      fr_active = 1'b0;
      r.status = ST_OVERFLOW;
      return r;
    end
    idx = fr_count;
    fr_count++;
    r.kept_valid = 1'b1;
    r.kept_byte = b;
    r.kept_index = IDX_W'(idx);
    if (fr_kind == KIND_ASCII) begin
      if (idx > 0 && b == CLOSE_MARK) begin
        fr_active = 1'b0;
        r.status = ST_DONE;
        r.frame_length = CNT_W'(fr_count);
      end
      return r;
    end
    if (idx == 0) fr_first = b;
    else if (idx == LEN_LOW_POS) fr_len_lo = b;
    else if (idx == LEN_HIGH_POS) fr_len_hi = b[3:0];
    if (fr_count == HEADER_CHECK && !(fr_first == OPEN_MARK && b == BIN_MARK)) begin
      fr_count = 0;
      r.discard = 1'b1;
      return r;
    end
    if (fr_count >= LEN_EXTRA && b == CLOSE_MARK &&
        int'(fr_len_lo) + int'(fr_len_hi) * 256 + LEN_EXTRA == fr_count) begin
      fr_active = 1'b0;
      r.status = ST_DONE;
      r.frame_length = CNT_W'(fr_count);
    end
    return r;
  endfunction

  function automatic logic [7:0] byte_other_than(input logic [7:0] v);
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == v);
    return b;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && results.valid && results.ready) begin
      if (reply_queue.size() == 0) begin
        $error("result transfer with nothing expected");
        error_count++;
      end else begin
        want = reply_queue.pop_front();
        check_field("status", 16'(want.status), 16'(results.status));
        check_field("kept_valid", 16'(want.kept_valid), 16'(results.kept_valid));
        check_field("kept_byte", 16'(want.kept_byte), 16'(results.kept_byte));
        check_field("kept_index", 16'(want.kept_index), 16'(results.kept_index));
        check_field("discard", 16'(want.discard), 16'(results.discard));
        check_field("frame_length", 16'(want.frame_length), 16'(results.frame_length));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst) results.ready <= !(idling && $urandom_range(99) < 22);
  end

  task automatic send_item(input logic [1:0] mode, input logic [15:0] head,
                           input logic [7:0] b);
    item_t it;
    while (idling && $urandom_range(99) < 22) begin
      @(negedge clk) items.valid <= 1'b0;
    end
    @(negedge clk);
    items.valid <= 1'b1;
    items.mode <= mode;
    items.request_head <= head;
    items.rx_byte <= b;
    it.mode = mode;
    it.request_head = head;
    it.rx_byte = b;
    do @(posedge clk); while (!items.ready);
    reply_queue.push_back(step_deframer(it));
    items_sent++;
  endtask

  task automatic send_start(input logic [15:0] head);
    send_item(MODE_START, head, 8'($urandom_range(255)));
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(MODE_BYTE, 16'($urandom_range(16'hFFFF)), b);
  endtask

  task automatic send_poll();
    send_item(MODE_POLL, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)));
  endtask

  task automatic send_unused();
    send_item(MODE_UNUSED, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)));
  endtask

  // waits until the block is drained, then writes the limit
  task automatic write_limit(input logic [15:0] value);
    @(negedge clk) items.valid <= 1'b0;
    while (reply_queue.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg.poll_timeout_limit <= value;
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    poll_limit = value;
    @(negedge clk) cfg.valid <= 1'b0;
  endtask

  task automatic test_ignored_while_idle();
    send_byte(8'hA5);
    send_poll();
    send_unused();
  endtask

  task automatic test_basic_ascii();
    send_start(16'hFFFF);
    send_unused();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(OPEN_MARK);
  endtask

  task automatic test_binary_frames();
    send_start({OPEN_MARK, BIN_MARK});
    send_byte(OPEN_MARK);
    send_byte(BIN_MARK);
    repeat (5) send_byte(8'($urandom_range(255)));
    send_byte(8'h00);
    send_byte(8'hF0);
    send_byte(CLOSE_MARK);
    send_byte(CLOSE_MARK);
    // header failure on the second byte, then a fresh header
    send_start({OPEN_MARK, BIN_MARK});
    send_byte(OPEN_MARK);
    send_byte(OPEN_MARK);
    send_byte(OPEN_MARK);
    send_byte(BIN_MARK);
  endtask

  task automatic test_ascii_frames();
    send_start({OPEN_MARK, 8'h00});
    send_byte(8'h41);
    send_byte(CLOSE_MARK);
    send_byte(OPEN_MARK);
    send_byte(CLOSE_MARK);
  endtask

  task automatic test_poll_timeout();
    write_limit(16'd0);
    send_start(16'h0000);
    send_poll();
    write_limit(16'd1);
    send_start({OPEN_MARK, 8'h01});
    send_poll();
    send_byte(OPEN_MARK);
    send_poll();
    write_limit(16'hFFFF);
    send_start({OPEN_MARK, BIN_MARK});
    send_poll();
    send_start({OPEN_MARK, 8'h02});
  endtask

  task automatic test_binary_high_length();
    send_start({OPEN_MARK, BIN_MARK});
    send_byte(OPEN_MARK);
    send_byte(BIN_MARK);
    repeat (5) send_byte(8'($urandom_range(255)));
    send_byte(8'h10);
    send_byte(8'hE1);
    for (int i = 9; i < 282; i++) send_byte(8'($urandom_range(255)));
    send_byte(CLOSE_MARK);
  endtask

  task automatic frame_byte(input logic [7:0] b);
    if ($urandom_range(99) < 8) send_poll();
    if ($urandom_range(99) < 2) send_unused();
    send_byte(b);
  endtask

  task automatic random_exchange();
    logic [7:0] frame_q[$];
    int         roll;
    int         len;
    int         nib;
    int         n;
    roll = $urandom_range(99);
    if (roll < 40) begin
      send_start({OPEN_MARK, BIN_MARK});
      if ($urandom_range(9) == 0) begin
        frame_q.push_back(8'($urandom_range(255)));
        frame_q.push_back(byte_other_than(BIN_MARK));
      end
      len = $urandom_range(24);
      nib = ($urandom_range(19) == 0) ? 1 : 0;
      frame_q.push_back(OPEN_MARK);
      frame_q.push_back(BIN_MARK);
      repeat (5) frame_q.push_back(8'($urandom_range(255)));
      frame_q.push_back(len[7:0]);
      frame_q.push_back({4'($urandom_range(15)), nib[3:0]});
      repeat (len + nib * 256) frame_q.push_back(8'($urandom_range(255)));
      frame_q.push_back(CLOSE_MARK);
    end else if (roll < 75) begin
      send_start({OPEN_MARK, byte_other_than(BIN_MARK)});
      repeat ($urandom_range(3)) frame_q.push_back(byte_other_than(OPEN_MARK));
      frame_q.push_back(OPEN_MARK);
      repeat ($urandom_range(20)) frame_q.push_back(byte_other_than(CLOSE_MARK));
      frame_q.push_back(CLOSE_MARK);
    end else if (roll < 90) begin
      send_start({byte_other_than(OPEN_MARK), 8'($urandom_range(255))});
      repeat ($urandom_range(3, 2)) frame_q.push_back(8'($urandom_range(255)));
    end else begin
      send_start(16'($urandom_range(16'hFFFF)));
      repeat ($urandom_range(12)) frame_q.push_back(8'($urandom_range(255)));
    end
    n = frame_q.size();
    if ($urandom_range(9) == 0) n = $urandom_range(n);
    for (int i = 0; i < n; i++) frame_byte(frame_q[i]);
    if ($urandom_range(9) == 0) begin
      if ($urandom_range(1)) send_poll();
      else send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic test_random_traffic();
    logic [15:0] limits[6];
    int          target;
    limits = '{16'd100, 16'd3, 16'd0, 16'hFFFF, 16'd12, 16'd1};
    for (int phase = 0; phase < 6; phase++) begin
      write_limit(phase == 4 ? 16'($urandom_range(16'hFFFF)) : limits[phase]);
      idling = (phase != 2);
      target = items_sent + 140;
      while (items_sent < target) random_exchange();
    end
    idling = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    items.valid = 1'b0;
    items.mode = MODE_START;
    items.request_head = '0;
    items.rx_byte = '0;
    cfg.valid = 1'b0;
    cfg.poll_timeout_limit = '0;
    results.ready = 1'b0;
    fr_active = 1'b0;
    fr_kind = KIND_BINARY;
    fr_count = 0;
    fr_first = '0;
    fr_len_lo = '0;
    fr_len_hi = '0;
    fr_polls = 0;
    poll_limit = LIMIT_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_ignored_while_idle();
    test_basic_ascii();
    test_binary_frames();
    test_ascii_frames();
    test_poll_timeout();
    write_limit(16'd100);
    test_binary_high_length();
    test_random_traffic();

    @(negedge clk) items.valid <= 1'b0;
    while (reply_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
